// File: src/ekfphf_pkg.sv
// ----------------------------------------------------------------------------
// ekfphf_pkg
// Types, constants and helper functions of the heading-aided pose filter.
// ----------------------------------------------------------------------------
package ekfphf_pkg;

	// number of rotation steps of the sine and cosine unit (8 to 24)
	localparam int CORDIC_STAGES = 16;
	localparam int COR_CW        = $clog2(CORDIC_STAGES);

	// divider magnitude widths
	localparam int DIV_NB = 65;
	localparam int DIV_DB = 35;
	localparam int DIV_CW = $clog2(DIV_NB);

	// angle constants, Q.29 radians; CORDIC_GAIN is Q.30 and HEAD_MAX is Q2.13
	localparam int ANG_W = 36;
	localparam logic signed [ANG_W-1:0] PI_Q29      = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q29  = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 36'sd843314857;
	localparam logic signed [33:0]      CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [15:0]      HEAD_MAX    = 16'sd25736;

	// reset values of the configuration registers
	localparam logic [30:0] PN_RESET  = 31'd16777;
	localparam logic [30:0] MN_RESET  = 31'd167772;
	localparam logic [30:0] COV_RESET = 31'd1677722;

	typedef struct packed {
		logic signed [15:0] linear_speed;
		logic signed [15:0] turn_rate;
		logic        [31:0] stamp_us;
		logic signed [15:0] heading_measured;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] est_x;
		logic signed [31:0] est_y;
		logic signed [15:0] est_heading;
		logic signed [31:0] cov_xx;
		logic signed [31:0] cov_xy;
		logic signed [31:0] cov_xt;
		logic signed [31:0] cov_yy;
		logic signed [31:0] cov_yt;
		logic signed [31:0] cov_tt;
	} result_t;

	typedef enum logic [2:0] {
		CFG_PROCESS_NOISE,
		CFG_MEAS_NOISE,
		CFG_INIT_COV,
		CFG_INIT_X,
		CFG_INIT_Y,
		CFG_INIT_HEADING,
		CFG_INIT_STAMP
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		U_ALU,
		U_MUL,
		U_DIV,
		U_COR
	} unit_t;

	// micro-operations, in program order
	typedef enum logic [5:0] {
		OP_COR0, OP_VDT, OP_DDIV, OP_DXS, OP_DYS,
		OP_WDT, OP_THDIV, OP_THWRAP, OP_COR1, OP_VS, OP_DXA, OP_VC, OP_DYA,
		OP_POSE,
		OP_UA, OP_UB, OP_A02, OP_AUA, OP_A12, OP_B02, OP_BUA, OP_B12, OP_BUB,
		OP_CPRED, OP_SCHK,
		OP_KX, OP_KXD, OP_KY, OP_KYD, OP_KT, OP_KTD, OP_HWRAP,
		OP_M00, OP_D00, OP_M01, OP_D01, OP_M02, OP_D02,
		OP_M11, OP_D11, OP_M12, OP_D12, OP_M22, OP_D22,
		OP_FIN
	} op_t;

	function automatic logic signed [33:0] atan_q29(input logic [4:0] i);
		logic signed [33:0] r;
		case (i)
			5'd0:  r = 34'sd421657428;
			5'd1:  r = 34'sd248918915;
			5'd2:  r = 34'sd131521918;
			5'd3:  r = 34'sd66762579;
			5'd4:  r = 34'sd33510843;
			5'd5:  r = 34'sd16771758;
			5'd6:  r = 34'sd8387925;
			5'd7:  r = 34'sd4194219;
			5'd8:  r = 34'sd2097141;
			5'd9:  r = 34'sd1048575;
			5'd10: r = 34'sd524288;
			5'd11: r = 34'sd262144;
			5'd12: r = 34'sd131072;
			5'd13: r = 34'sd65536;
			5'd14: r = 34'sd32768;
			5'd15: r = 34'sd16384;
			5'd16: r = 34'sd8192;
			5'd17: r = 34'sd4096;
			5'd18: r = 34'sd2048;
			5'd19: r = 34'sd1024;
			5'd20: r = 34'sd512;
			5'd21: r = 34'sd256;
			5'd22: r = 34'sd128;
			5'd23: r = 34'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// wrap into (-pi, pi] for values below four pi in magnitude
	function automatic logic signed [ANG_W-1:0] wrap_small(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a;
		if (a >= TWO_PI_Q29) begin
			r = a - TWO_PI_Q29;
		end else if (a <= -TWO_PI_Q29) begin
			r = a + TWO_PI_Q29;
		end
		if (r > PI_Q29) begin
			r = r - TWO_PI_Q29;
		end else if (r <= -PI_Q29) begin
			r = r + TWO_PI_Q29;
		end
		return r;
	endfunction

	// Q.29 to Q2.13 with rounding and clamp
	function automatic logic signed [15:0] to_q13(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] t;
		logic signed [15:0] r;
		t = (a + 36'sd32768) >>> 16;
		if (t > 36'(HEAD_MAX)) begin
			r = HEAD_MAX;
		end else if (t < -36'(HEAD_MAX)) begin
			r = -HEAD_MAX;
		end else begin
			r = t[15:0];
		end
		return r;
	endfunction

endpackage

// File: src/ekf_pose_heading_fusion_top.sv
// ----------------------------------------------------------------------------
// ekf_pose_heading_fusion_top
// Each word runs one program of micro-ops on the shared multiplier, divider
// and sine and cosine unit: the arc model, or the straight one at zero turn
// rate, then the heading correction unless its gain is degenerate. Words are
// taken singly; a new word is taken while the last result waits at the output.
// Reset (async, active low) loads register defaults and the default pose.
// ----------------------------------------------------------------------------
module ekf_pose_heading_fusion_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  ekfphf_pkg::sample_t  sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ekfphf_pkg::result_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import ekfphf_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_nx;
	unit_t  unit;
	logic   op_done;

	// sample and filter state
	logic signed [15:0] v_q, w_q, z_q, head_q;
	logic [31:0] dt_q, last_stamp_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic signed [31:0] p00_q, p01_q, p02_q, p11_q, p12_q, p22_q;
	logic [30:0] pn_q, mn_q;

	// working registers
	logic signed [ANG_W-1:0] thw_q, th2w_q;
	logic signed [45:0] th2_q;
	logic signed [47:0] hs_q, dx_q, dy_q;
	logic signed [33:0] s0_q, c0_q, s1_q, c1_q, d_q, s_q;
	logic signed [31:0] a_q, b_q, ua_q, ub_q;
	logic signed [31:0] a02_q, aua_q, a12_q, b02_q, bua_q, b12_q, bub_q;
	logic signed [15:0] e_q;
	result_t result_q;
	logic result_valid_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;
	logic signed [65:0] prod66;

	// shared divider
	logic signed [65:0] div_n;
	logic signed [35:0] div_d;
	logic div_rnd;
	logic [65:0] neg_n;
	logic [35:0] neg_d;
	logic [DIV_NB-1:0] n_mag, n_adj, dn_q;
	logic [DIV_DB-1:0] d_mag, dr_q, dm_q;
	logic [DIV_DB:0] trial, trial_diff;
	logic trial_ge;
	logic [DIV_CW-1:0] dcnt_q;
	logic dbusy_q, dnneg_q, dqneg_q, dz_q;
	logic signed [65:0] quot;
	logic signed [35:0] rem;

	// shared sine and cosine unit
	logic signed [ANG_W-1:0] cor_ang, cor_pre;
	logic cor_flip;
	logic signed [33:0] cx_q, cy_q, ca_q, cor_s, cor_c;
	logic cflip_q, cbusy_q;
	logic [COR_CW-1:0] cit_q;

	// alu helpers
	logic signed [31:0] pn_s, mn_s;
	logic signed [33:0] s_next;
	logic signed [15:0] e_next;
	logic signed [16:0] innov;
	logic signed [31:0] t_sat;
	logic signed [67:0] sr30;
	logic signed [65:0] d_clamp;

	assign pn_s   = $signed({1'b0, pn_q});
	assign mn_s   = $signed({1'b0, mn_q});
	assign prod66 = prod_q[65:0];
	assign t_sat  = sat32((prod_q + 68'sd32768) >>> 16);
	assign sr30   = (prod_q + (68'sd1 <<< 29)) >>> 30;
	assign s_next = 34'(p22_q) + 34'(mn_s);
	assign innov  = 17'(z_q) - 17'(head_q);
	assign e_next = to_q13(wrap_small(36'(innov) <<< 16));

	always_comb begin
		if (quot > 66'sh1_0000_0000) begin
			d_clamp = 66'sh1_0000_0000;
		end else if (quot < -66'sh1_0000_0000) begin
			d_clamp = -66'sh1_0000_0000;
		end else begin
			d_clamp = quot;
		end
	end

	// unit selection and operands of the current micro-op
	always_comb begin
		unit    = U_ALU;
		mul_a   = '0;
		mul_b   = '0;
		div_n   = prod66;
		div_d   = 36'(s_q);
		div_rnd = 1'b1;
		cor_ang = thw_q;
		case (op_q)
			OP_COR0: unit = U_COR;
			OP_COR1: begin
				unit    = U_COR;
				cor_ang = th2w_q;
			end
			OP_VDT:  begin unit = U_MUL; mul_a = 34'(v_q); mul_b = 34'({1'b0, dt_q}); end
			OP_WDT:  begin unit = U_MUL; mul_a = 34'(w_q); mul_b = 34'({1'b0, dt_q}); end
			OP_DXS:  begin unit = U_MUL; mul_a = d_q; mul_b = c0_q; end
			OP_DYS:  begin unit = U_MUL; mul_a = d_q; mul_b = s0_q; end
			OP_VS:   begin unit = U_MUL; mul_a = 34'(v_q); mul_b = s1_q - s0_q; end
			OP_VC:   begin unit = U_MUL; mul_a = 34'(v_q); mul_b = c0_q - c1_q; end
			OP_UA:   begin unit = U_MUL; mul_a = 34'(a_q); mul_b = 34'(p22_q); end
			OP_UB:   begin unit = U_MUL; mul_a = 34'(b_q); mul_b = 34'(p22_q); end
			OP_A02:  begin unit = U_MUL; mul_a = 34'(a_q); mul_b = 34'(p02_q); end
			OP_AUA:  begin unit = U_MUL; mul_a = 34'(a_q); mul_b = 34'(ua_q); end
			OP_A12:  begin unit = U_MUL; mul_a = 34'(a_q); mul_b = 34'(p12_q); end
			OP_B02:  begin unit = U_MUL; mul_a = 34'(b_q); mul_b = 34'(p02_q); end
			OP_BUA:  begin unit = U_MUL; mul_a = 34'(b_q); mul_b = 34'(ua_q); end
			OP_B12:  begin unit = U_MUL; mul_a = 34'(b_q); mul_b = 34'(p12_q); end
			OP_BUB:  begin unit = U_MUL; mul_a = 34'(b_q); mul_b = 34'(ub_q); end
			OP_KX:   begin unit = U_MUL; mul_a = 34'(p02_q); mul_b = 34'(e_q); end
			OP_KY:   begin unit = U_MUL; mul_a = 34'(p12_q); mul_b = 34'(e_q); end
			OP_KT:   begin unit = U_MUL; mul_a = 34'(p22_q); mul_b = 34'(e_q); end
			OP_M00:  begin unit = U_MUL; mul_a = 34'(p02_q); mul_b = 34'(p02_q); end
			OP_M01:  begin unit = U_MUL; mul_a = 34'(p02_q); mul_b = 34'(p12_q); end
			OP_M02:  begin unit = U_MUL; mul_a = 34'(p02_q); mul_b = 34'(p22_q); end
			OP_M11:  begin unit = U_MUL; mul_a = 34'(p12_q); mul_b = 34'(p12_q); end
			OP_M12:  begin unit = U_MUL; mul_a = 34'(p12_q); mul_b = 34'(p22_q); end
			OP_M22:  begin unit = U_MUL; mul_a = 34'(p22_q); mul_b = 34'(p22_q); end
			OP_DDIV: begin
				unit  = U_DIV;
				div_n = prod66 <<< 4;
				div_d = 36'sd1000000;
			end
			OP_THDIV: begin
				unit  = U_DIV;
				div_n = prod66 <<< 10;
				div_d = 36'sd15625;
			end
			OP_THWRAP: begin
				unit    = U_DIV;
				div_n   = 66'(th2_q);
				div_d   = TWO_PI_Q29;
				div_rnd = 1'b0;
			end
			OP_DXA, OP_DYA: begin
				unit  = U_DIV;
				div_d = 36'(w_q) <<< 13;
			end
			OP_KXD, OP_KYD: begin
				unit  = U_DIV;
				div_n = prod66 <<< 3;
			end
			OP_HWRAP: begin
				unit    = U_DIV;
				div_n   = 66'(hs_q) <<< 16;
				div_d   = TWO_PI_Q29;
				div_rnd = 1'b0;
			end
			OP_KTD, OP_D00, OP_D01, OP_D02, OP_D11, OP_D12, OP_D22: unit = U_DIV;
			default: unit = U_ALU;
		endcase
	end

	// program sequencing
	always_comb begin
		case (op_q)
			OP_COR0: op_nx = (w_q == 16'sd0) ? OP_VDT : OP_WDT;
			OP_DYS:  op_nx = OP_POSE;
			OP_SCHK: op_nx = (s_next > 34'sd0) ? OP_KX : OP_FIN;
			OP_FIN:  op_nx = OP_FIN;
			default: op_nx = op_t'(op_q + 6'd1);
		endcase
	end

	always_comb begin
		case (unit)
			U_DIV:   op_done = !dbusy_q;
			U_COR:   op_done = !cbusy_q;
			default: op_done = 1'b1;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake; a register write takes the idle cycle first
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = !cfg_valid;
				if (sample_valid && !cfg_valid) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (op_done) begin
					state_d = (op_q == OP_FIN) ? ST_OUT : ST_ISSUE;
				end
			end
			ST_OUT: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// multiplier, product registered
	always_ff @(posedge clk) begin
		if (state_q == ST_ISSUE && unit == U_MUL) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// divider operand conditioning
	always_comb begin
		neg_n = -div_n;
		neg_d = -div_d;
		n_mag = div_n[65] ? neg_n[DIV_NB-1:0] : div_n[DIV_NB-1:0];
		d_mag = div_d[35] ? neg_d[DIV_DB-1:0] : div_d[DIV_DB-1:0];
		n_adj = n_mag + (div_rnd ? DIV_NB'(d_mag >> 1) : '0);
	end

	// one restoring step per cycle
	assign trial      = {dr_q, dn_q[DIV_NB-1]};
	assign trial_ge   = trial >= {1'b0, dm_q};
	assign trial_diff = trial - {1'b0, dm_q};

	always_comb begin
		if (dz_q) begin
			quot = '0;
		end else if (dqneg_q) begin
			quot = -$signed({1'b0, dn_q});
		end else begin
			quot = $signed({1'b0, dn_q});
		end
		rem = dnneg_q ? -$signed({1'b0, dr_q}) : $signed({1'b0, dr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
		end else if (state_q == ST_ISSUE && unit == U_DIV) begin
			dbusy_q <= 1'b1;
			dcnt_q  <= '0;
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (dcnt_q == DIV_CW'(DIV_NB - 1)) begin
				dbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ISSUE && unit == U_DIV) begin
			dn_q    <= n_adj;
			dr_q    <= '0;
			dm_q    <= d_mag;
			dnneg_q <= div_n[65];
			dqneg_q <= div_n[65] ^ div_d[35];
			dz_q    <= (d_mag == '0);
		end else if (dbusy_q) begin
			dn_q <= {dn_q[DIV_NB-2:0], trial_ge};
			dr_q <= trial_ge ? trial_diff[DIV_DB-1:0] : trial[DIV_DB-1:0];
		end
	end

	// sine and cosine: fold to the right half plane, then rotate
	always_comb begin
		cor_pre  = cor_ang;
		cor_flip = 1'b0;
		if (cor_ang > HALF_PI_Q29) begin
			cor_pre  = cor_ang - PI_Q29;
			cor_flip = 1'b1;
		end else if (cor_ang < -HALF_PI_Q29) begin
			cor_pre  = cor_ang + PI_Q29;
			cor_flip = 1'b1;
		end
	end

	assign cor_c = cflip_q ? -cx_q : cx_q;
	assign cor_s = cflip_q ? -cy_q : cy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbusy_q <= 1'b0;
			cit_q   <= '0;
		end else if (state_q == ST_ISSUE && unit == U_COR) begin
			cbusy_q <= 1'b1;
			cit_q   <= '0;
		end else if (cbusy_q) begin
			cit_q <= cit_q + 1'b1;
			if (cit_q == COR_CW'(CORDIC_STAGES - 1)) begin
				cbusy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ISSUE && unit == U_COR) begin
			cx_q    <= CORDIC_GAIN;
			cy_q    <= '0;
			ca_q    <= cor_pre[33:0];
			cflip_q <= cor_flip;
		end else if (cbusy_q) begin
			if (ca_q >= 34'sd0) begin
				cx_q <= cx_q - (cy_q >>> cit_q);
				cy_q <= cy_q + (cx_q >>> cit_q);
				ca_q <= ca_q - atan_q29(5'(cit_q));
			end else begin
				cx_q <= cx_q + (cy_q >>> cit_q);
				cy_q <= cy_q - (cx_q >>> cit_q);
				ca_q <= ca_q + atan_q29(5'(cit_q));
			end
		end
	end

	// micro-op register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_COR0;
		end else if (sample_valid && sample_ready) begin
			op_q <= OP_COR0;
		end else if (state_q == ST_WAIT && op_done) begin
			op_q <= op_nx;
		end
	end

	// filter state, configuration and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q         <= PN_RESET;
			mn_q         <= MN_RESET;
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			head_q       <= '0;
			last_stamp_q <= '0;
			p00_q        <= $signed({1'b0, COV_RESET});
			p01_q        <= '0;
			p02_q        <= '0;
			p11_q        <= $signed({1'b0, COV_RESET});
			p12_q        <= '0;
			p22_q        <= $signed({1'b0, COV_RESET});
		end else if (state_q == ST_IDLE && cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PROCESS_NOISE: pn_q <= cfg_data[30:0];
				CFG_MEAS_NOISE:    mn_q <= cfg_data[30:0];
				CFG_INIT_COV: begin
					p00_q <= $signed({1'b0, cfg_data[30:0]});
					p11_q <= $signed({1'b0, cfg_data[30:0]});
					p22_q <= $signed({1'b0, cfg_data[30:0]});
					p01_q <= '0;
					p02_q <= '0;
					p12_q <= '0;
				end
				CFG_INIT_X:       pose_x_q <= cfg_data;
				CFG_INIT_Y:       pose_y_q <= cfg_data;
				CFG_INIT_HEADING: begin
					head_q <= to_q13(wrap_small(36'($signed(cfg_data[15:0])) <<< 16));
				end
				CFG_INIT_STAMP:   last_stamp_q <= cfg_data;
				default: ;
			endcase
		end else if (sample_valid && sample_ready) begin
			last_stamp_q <= sample.stamp_us;
		end else if (state_q == ST_WAIT && op_done) begin
			case (op_q)
				OP_POSE: begin
					pose_x_q <= sat32(68'(pose_x_q) + 68'(dx_q));
					pose_y_q <= sat32(68'(pose_y_q) + 68'(dy_q));
					head_q   <= to_q13(th2w_q);
				end
				OP_CPRED: begin
					p00_q <= sat32(68'(p00_q) + (68'(a02_q) <<< 1) + 68'(aua_q) + 68'(pn_s));
					p01_q <= sat32(68'(p01_q) + 68'(a12_q) + 68'(b02_q) + 68'(bua_q));
					p02_q <= sat32(68'(p02_q) + 68'(ua_q));
					p11_q <= sat32(68'(p11_q) + (68'(b12_q) <<< 1) + 68'(bub_q) + 68'(pn_s));
					p12_q <= sat32(68'(p12_q) + 68'(ub_q));
					p22_q <= sat32(68'(p22_q) + 68'(pn_s));
				end
				OP_KXD:  pose_x_q <= sat32(68'(pose_x_q) + 68'(quot));
				OP_KYD:  pose_y_q <= sat32(68'(pose_y_q) + 68'(quot));
				OP_HWRAP: head_q <= to_q13(wrap_small(rem));
				OP_D00:  p00_q <= sat32(68'(p00_q) - 68'(quot));
				OP_D01:  p01_q <= sat32(68'(p01_q) - 68'(quot));
				OP_D02:  p02_q <= sat32(68'(p02_q) - 68'(quot));
				OP_D11:  p11_q <= sat32(68'(p11_q) - 68'(quot));
				OP_D12:  p12_q <= sat32(68'(p12_q) - 68'(quot));
				OP_D22:  p22_q <= sat32(68'(p22_q) - 68'(quot));
				default: ;
			endcase
		end
	end

	// working registers of one word
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			v_q   <= sample.linear_speed;
			w_q   <= sample.turn_rate;
			z_q   <= sample.heading_measured;
			dt_q  <= sample.stamp_us - last_stamp_q;
			thw_q <= wrap_small(36'(head_q) <<< 16);
		end else if (state_q == ST_WAIT && op_done) begin
			case (op_q)
				OP_COR0: begin
					s0_q <= cor_s;
					c0_q <= cor_c;
				end
				OP_COR1: begin
					s1_q <= cor_s;
					c1_q <= cor_c;
				end
				OP_DDIV:   d_q <= d_clamp[33:0];
				OP_DXS:    dx_q <= sr30[47:0];
				OP_DYS: begin
					dy_q   <= sr30[47:0];
					th2w_q <= thw_q;
				end
				OP_THDIV:  th2_q <= 46'(thw_q) + quot[45:0];
				OP_THWRAP: th2w_q <= wrap_small(rem);
				OP_DXA:    dx_q <= quot[47:0];
				OP_DYA:    dy_q <= quot[47:0];
				OP_POSE: begin
					a_q <= sat32(-68'(dy_q));
					b_q <= sat32(68'(dx_q));
				end
				OP_UA:  ua_q  <= t_sat;
				OP_UB:  ub_q  <= t_sat;
				OP_A02: a02_q <= t_sat;
				OP_AUA: aua_q <= t_sat;
				OP_A12: a12_q <= t_sat;
				OP_B02: b02_q <= t_sat;
				OP_BUA: bua_q <= t_sat;
				OP_B12: b12_q <= t_sat;
				OP_BUB: bub_q <= t_sat;
				OP_SCHK: begin
					s_q <= s_next;
					e_q <= e_next;
				end
				OP_KTD: hs_q <= 48'(head_q) + quot[47:0];
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!result_valid_q || result_ready)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!result_valid_q || result_ready)) begin
			result_q.est_x       <= pose_x_q;
			result_q.est_y       <= pose_y_q;
			result_q.est_heading <= head_q;
			result_q.cov_xx      <= p00_q;
			result_q.cov_xy      <= p01_q;
			result_q.cov_xt      <= p02_q;
			result_q.cov_yy      <= p11_q;
			result_q.cov_yt      <= p12_q;
			result_q.cov_tt      <= p22_q;
		end
	end

endmodule

// File: test/ekf_pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ekf_pose_checker
// Watches the sample, result and register channels of the pose filter. It
// tracks the filter state on its own, computes the pose and covariance due
// for every accepted sample, and compares each result word against them.
// ----------------------------------------------------------------------------
module ekf_pose_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_ready,
	input  ekfphf_pkg::sample_t  sample,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  ekfphf_pkg::result_t  result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fails,
	output int                   pending
);
	import ekfphf_pkg::*;

	localparam longint A_PI      = 64'sd1686629713;
	localparam longint A_TWO_PI  = 64'sd3373259426;
	localparam longint A_HALF_PI = 64'sd843314857;
	localparam longint K_GAIN    = 64'sd652032874;
	localparam longint H_LIM     = 64'sd25736;
	localparam longint S32_MAX   = 64'sd2147483647;
	localparam longint S32_MIN   = -64'sd2147483648;

	longint atan_tab [24] = '{
		421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
		8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64
	};

	// register copies and tracked filter state
	longint q_proc, q_meas, q_init_cov;
	longint px, py, ph, last_t;
	longint cv [6];

	result_t pose_q [$];

	function automatic longint clip32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	function automatic longint rshift_rnd(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// division rounding half away from zero
	function automatic longint div_away(input longint n, input longint d);
		longint unsigned mn, md, q;
		mn = n < 0 ? longint'(-n) : n;
		md = d < 0 ? longint'(-d) : d;
		if (md == 0) return 0;
		q = (mn + md / 2) / md;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint ang_wrap(input longint a);
		longint r;
		r = a % A_TWO_PI;
		if (r > A_PI) r -= A_TWO_PI;
		if (r <= -A_PI) r += A_TWO_PI;
		return r;
	endfunction

	function automatic longint ang_q13(input longint a);
		longint r;
		r = rshift_rnd(a, 16);
		if (r > H_LIM) r = H_LIM;
		if (r < -H_LIM) r = -H_LIM;
		return r;
	endfunction

	function automatic longint head_wrap(input longint h);
		return ang_q13(ang_wrap(h * 65536));
	endfunction

	task automatic rot_sincos(input longint ang, output longint s, output longint c);
		longint x, y, nx, a;
		bit flip;
		x = K_GAIN;
		y = 0;
		flip = 0;
		a = ang_wrap(ang);
		if (a > A_HALF_PI) begin
			a -= A_PI;
			flip = 1;
		end else if (a < -A_HALF_PI) begin
			a += A_PI;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				a -= atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				a += atan_tab[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic load_diag();
		cv[0] = q_init_cov;
		cv[3] = q_init_cov;
		cv[5] = q_init_cov;
		cv[1] = 0;
		cv[2] = 0;
		cv[4] = 0;
	endtask

	// one predict and heading-correct pass
	task automatic filter_update(input sample_t smp, output result_t r);
		longint v, w, z, dt, th, th2, s0, c0, s1, c1, dx, dy, a, b, ua, ub, sden, d, e;
		longint p00, p01, p02, p11, p12, p22;
		v = smp.linear_speed;
		w = smp.turn_rate;
		z = smp.heading_measured;
		dt = (longint'(smp.stamp_us) - last_t) & 64'hFFFF_FFFF;
		last_t = smp.stamp_us;
		th = ph * 65536;
		rot_sincos(th, s0, c0);
		if (w == 0) begin
			d = div_away(v * dt * 16, 1000000);
			if (d > 64'sd4294967296) d = 64'sd4294967296;
			if (d < -64'sd4294967296) d = -64'sd4294967296;
			dx = rshift_rnd(d * c0, 30);
			dy = rshift_rnd(d * s0, 30);
			th2 = th;
		end else begin
			th2 = th + div_away(w * dt * 1024, 15625);
			rot_sincos(th2, s1, c1);
			dx = div_away(v * (s1 - s0), w * 8192);
			dy = div_away(v * (c0 - c1), w * 8192);
		end
		px = clip32(px + dx);
		py = clip32(py + dy);
		ph = ang_q13(ang_wrap(th2));

		// covariance through the motion jacobian
		a = clip32(-dy);
		b = clip32(dx);
		p00 = cv[0]; p01 = cv[1]; p02 = cv[2];
		p11 = cv[3]; p12 = cv[4]; p22 = cv[5];
		ua = clip32(rshift_rnd(a * p22, 16));
		ub = clip32(rshift_rnd(b * p22, 16));
		cv[0] = clip32(p00 + 2 * clip32(rshift_rnd(a * p02, 16))
			+ clip32(rshift_rnd(a * ua, 16)) + q_proc);
		cv[1] = clip32(p01 + clip32(rshift_rnd(a * p12, 16))
			+ clip32(rshift_rnd(b * p02, 16)) + clip32(rshift_rnd(b * ua, 16)));
		cv[2] = clip32(p02 + ua);
		cv[3] = clip32(p11 + 2 * clip32(rshift_rnd(b * p12, 16))
			+ clip32(rshift_rnd(b * ub, 16)) + q_proc);
		cv[4] = clip32(p12 + ub);
		cv[5] = clip32(p22 + q_proc);

		// heading-only correction, skipped on a degenerate gain
		p00 = cv[0]; p01 = cv[1]; p02 = cv[2];
		p11 = cv[3]; p12 = cv[4]; p22 = cv[5];
		sden = p22 + q_meas;
		if (sden > 0) begin
			e = head_wrap(z - ph);
			px = clip32(px + div_away(p02 * e * 8, sden));
			py = clip32(py + div_away(p12 * e * 8, sden));
			ph = head_wrap(ph + div_away(p22 * e, sden));
			cv[0] = clip32(p00 - div_away(p02 * p02, sden));
			cv[1] = clip32(p01 - div_away(p02 * p12, sden));
			cv[2] = clip32(p02 - div_away(p02 * p22, sden));
			cv[3] = clip32(p11 - div_away(p12 * p12, sden));
			cv[4] = clip32(p12 - div_away(p12 * p22, sden));
			cv[5] = clip32(p22 - div_away(p22 * p22, sden));
		end
		r.est_x       = px[31:0];
		r.est_y       = py[31:0];
		r.est_heading = ph[15:0];
		r.cov_xx      = cv[0][31:0];
		r.cov_xy      = cv[1][31:0];
		r.cov_xt      = cv[2][31:0];
		r.cov_yy      = cv[3][31:0];
		r.cov_yt      = cv[4][31:0];
		r.cov_tt      = cv[5][31:0];
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [31:0] val);
		case (cfg_reg_t'(idx))
			CFG_PROCESS_NOISE: q_proc = val[30:0];
			CFG_MEAS_NOISE:    q_meas = val[30:0];
			CFG_INIT_COV: begin
				q_init_cov = val[30:0];
				load_diag();
			end
			CFG_INIT_X:        px = longint'($signed(val));
			CFG_INIT_Y:        py = longint'($signed(val));
			CFG_INIT_HEADING:  ph = head_wrap(longint'($signed(val[15:0])));
			CFG_INIT_STAMP:    last_t = val;
			default: ;
		endcase
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			q_proc = PN_RESET;
			q_meas = MN_RESET;
			q_init_cov = COV_RESET;
			px = 0;
			py = 0;
			ph = 0;
			last_t = 0;
			load_diag();
			pose_q.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			if (result_valid && result_ready) begin
				got = result;
				if (pose_q.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					want = pose_q.pop_front();
					if (got.est_x != want.est_x) report("est_x", got.est_x, want.est_x);
					if (got.est_y != want.est_y) report("est_y", got.est_y, want.est_y);
					if (got.est_heading != want.est_heading)
						report("est_heading", got.est_heading, want.est_heading);
					if (got.cov_xx != want.cov_xx) report("cov_xx", got.cov_xx, want.cov_xx);
					if (got.cov_xy != want.cov_xy) report("cov_xy", got.cov_xy, want.cov_xy);
					if (got.cov_xt != want.cov_xt) report("cov_xt", got.cov_xt, want.cov_xt);
					if (got.cov_yy != want.cov_yy) report("cov_yy", got.cov_yy, want.cov_yy);
					if (got.cov_yt != want.cov_yt) report("cov_yt", got.cov_yt, want.cov_yt);
					if (got.cov_tt != want.cov_tt) report("cov_tt", got.cov_tt, want.cov_tt);
				end
			end
			if (sample_valid && sample_ready) begin
				filter_update(sample, want);
				pose_q.push_back(want);
			end
		end
		pending = pose_q.size();
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the pose filter with directed and random odometry words over several
// register settings, with random stalls on both sides, and gives the verdict
// from the checker's mismatch count and its count of words still pending.
// ----------------------------------------------------------------------------
module tb;
	import ekfphf_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        sample_valid = 0;
	logic        sample_ready;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_ready = 0;
	result_t     result;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fails;
	int          pending;
	bit          calm = 0;
	int          cycles = 0;
	logic [31:0] cur_stamp = 0;

	ekf_pose_heading_fusion_top i_dut (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	ekf_pose_checker i_chk (
		.clk, .arst_n, .sample_valid, .sample_ready, .sample,
		.result_valid, .result_ready, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fails, .pending
	);

	always #5 clk = ~clk;

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		result_ready <= calm || ($urandom_range(99) >= 38);
	end

	task automatic send_word(input sample_t s);
		bit hs;
		bit idle;
		sample <= s;
		sample_valid <= 1;
		do begin
			@(negedge clk);
			hs = sample_ready;
			@(posedge clk);
		end while (!hs);
		idle = 0;
		while (!calm && $urandom_range(99) < 38) begin
			if (!idle) sample_valid <= 0;
			idle = 1;
			@(posedge clk);
		end
	endtask

	task automatic send_fields(input int v, input int w, input logic [31:0] dstamp,
			input int z);
		sample_t s;
		cur_stamp = cur_stamp + dstamp;
		s.linear_speed = 16'(v);
		s.turn_rate = 16'(w);
		s.stamp_us = cur_stamp;
		s.heading_measured = 16'(z);
		send_word(s);
	endtask

	task automatic reg_write(input cfg_reg_t idx, input logic [31:0] val);
		bit hs;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do begin
			@(negedge clk);
			hs = cfg_ready;
			@(posedge clk);
		end while (!hs);
		if (idx == CFG_INIT_STAMP) cur_stamp = val;
	endtask

	// wait until every expected word has come back, sampled away from the edge
	task automatic drain();
		if (sample_valid) sample_valid <= 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// register settings per phase: defaults, two sets of extreme values, then random
	task automatic set_phase(input int p);
		logic [31:0] r [7];
		case (p)
			0: r = '{16777, 167772, 1677722, 0, 0, 0, 0};
			1: r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 25736, 32'hFFFF_FFF0};
			2: r = '{0, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF, -25736, 0};
			default: begin
				r[0] = $urandom_range(0, 32'h0100_0000);
				r[1] = 1 + $urandom_range(0, 32'h0100_0000);
				r[2] = ($urandom_range(3) == 0) ? ($urandom & 32'h7FFF_FFFF)
					: $urandom_range(0, 32'h0400_0000);
				r[3] = $urandom;
				r[4] = $urandom;
				r[5] = $urandom_range(0, 51472) - 25736;
				r[6] = $urandom;
			end
		endcase
		for (int i = 0; i < 7; i++) reg_write(cfg_reg_t'(i), r[i]);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic send_random();
		int v, w, z;
		logic [31:0] ds;
		int m;
		v = ($urandom_range(99) < 80) ? $urandom_range(0, 8000) : $urandom_range(0, 32767);
		if ($urandom_range(1)) v = -v - ($urandom_range(9) == 0);
		m = $urandom_range(99);
		if (m < 15) w = 0;
		else if (m < 75) w = $urandom_range(0, 4000) - 2000;
		else w = $signed(16'($urandom));
		m = $urandom_range(99);
		if (m < 80) ds = $urandom_range(1000, 100000);
		else if (m < 88) ds = 0;
		else if (m < 94) ds = $urandom_range(1, 10);
		else ds = $urandom;
		z = $urandom_range(0, 51472) - 25736;
		send_fields(v, w, ds, z);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed words under the default setting
		set_phase(0);
		send_fields(0, 0, 0, 0);
		send_fields(32767, 0, 10000, 25736);
		send_fields(-32768, 0, 10000, -25736);
		send_fields(32767, 0, 32'hFFFF_FFFF, 0);
		send_fields(-32768, 0, 32'hF000_0000, 25736);
		send_fields(1000, 32767, 20000, 100);
		send_fields(1000, -32768, 20000, -100);
		send_fields(32767, 1, 1, 25736);
		send_fields(-32768, -1, 1000000, -25736);
		send_fields(0, 500, 0, 0);
		send_fields(200, 0, 1000, -25736);
		send_fields(200, 0, 1000, 25736);
		send_fields(-5, 12345, 32'h8000_0000, 1);
		for (int i = 0; i < 315; i++) send_random();
		drain();

		for (int p = 1; p < 9; p++) begin
			set_phase(p);
			if (p == 1) begin
				send_fields(32767, 32767, 32'h20, 25736);
				send_fields(-32768, 0, 32'hFFFF_FFFF, -25736);
			end
			calm = (p == 4);
			for (int i = 0; i < ((p < 3) ? 100 : 220); i++) begin
				if (p == 5 && i == 100) drain();
				send_random();
			end
			calm = 0;
			drain();
		end

		repeat (2000) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
